// ===== rtl/mahs_pkg.sv =====
// Shared types and constants for the moving average hysteresis alert block.
package mahs_pkg;

	localparam int SAMPLE_W  = 15;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 1;
	localparam int TDATA_W   = 16;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [CFG_W-1:0]    thr_t;

	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 1'b1;

	localparam thr_t HIGH_THR_RESET = 15'sd3000;
	localparam thr_t LOW_THR_RESET  = 15'sd2800;

endpackage

// ===== rtl/moving_average_hysteresis_alert.sv =====
// An accepted item passes the running total, divider product and output registers to the port.
// Throughput: one item per cycle unless output stalls; total and hot flag are per-item loops.
// Back-pressure stalls each stage only when the stage after it is full.
// Reset clears the sample cells, running total, hot flag and pipeline valids, and
// loads the thresholds with 30.00 C and 28.00 C; no clearing pass is needed.
module moving_average_hysteresis_alert #(
	parameter int WINDOW = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [mahs_pkg::TDATA_W-1:0]       s_axis_tdata,  // [14:0] temp_sample
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [mahs_pkg::TDATA_W-1:0]       m_axis_tdata,  // [14:0] smoothed_temp, [15] hot_alert
	input  logic                               cfg_we,
	input  logic [mahs_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mahs_pkg::CFG_W-1:0]         cfg_data
);

	localparam int TOTAL_W = mahs_pkg::SAMPLE_W + $clog2(WINDOW);

	mahs_pkg::sample_t            taps [WINDOW+1];
	mahs_pkg::sample_t            in_sample;
	mahs_pkg::sample_t            avg;
	mahs_pkg::thr_t               high_thr_q;
	mahs_pkg::thr_t               low_thr_q;
	logic signed [TOTAL_W-1:0]    total_q;
	logic                         valid_s1;
	logic                         valid_s2;
	logic                         hot_q;
	logic                         hot_next;
	logic                         accept;
	logic                         en2;
	logic                         en3;
	logic                         free3;
	logic                         out_valid_q;
	logic [mahs_pkg::TDATA_W-1:0] out_data_q;

	assign in_sample = s_axis_tdata[mahs_pkg::SAMPLE_W-1:0];
	assign taps[0]   = in_sample;

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		mahs_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (accept),
			.din   (taps[i]),
			.dout  (taps[i+1])
		);
	end

	assign free3         = !out_valid_q || m_axis_tready;
	assign en3           = valid_s2 && free3;
	assign en2           = valid_s1 && (!valid_s2 || en3);
	assign s_axis_tready = !valid_s1 || en2;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= mahs_pkg::HIGH_THR_RESET;
			low_thr_q  <= mahs_pkg::LOW_THR_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				mahs_pkg::REG_HIGH_THR: high_thr_q <= cfg_data;
				mahs_pkg::REG_LOW_THR:  low_thr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				total_q <= total_q + TOTAL_W'(in_sample) - TOTAL_W'(taps[WINDOW]);
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (en2) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	mahs_div #(
		.WINDOW (WINDOW),
		.TOTAL_W(TOTAL_W)
	) u_div (
		.clk  (clk),
		.en   (en2),
		.total(total_q),
		.avg  (avg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= 1'b1;
		end else if (en3) begin
			valid_s2 <= 1'b0;
		end
	end

	always_comb begin
		if (avg > high_thr_q) begin
			hot_next = 1'b1;
		end else if (avg < low_thr_q) begin
			hot_next = 1'b0;
		end else begin
			hot_next = hot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hot_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en3) begin
				hot_q       <= hot_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			out_data_q <= {hot_next, avg};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/mahs_cell.sv =====
// One sample cell of the window shift line.
module mahs_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift,
	input  mahs_pkg::sample_t din,
	output mahs_pkg::sample_t dout
);

	mahs_pkg::sample_t sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift) begin
			sample_q <= din;
		end
	end

	assign dout = sample_q;

endmodule

// ===== rtl/mahs_div.sv =====
// Divide the window total by WINDOW with a registered reciprocal multiply.
module mahs_div #(
	parameter int WINDOW  = 5,
	parameter int TOTAL_W = 18
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [TOTAL_W-1:0] total,
	output mahs_pkg::sample_t         avg
);

	localparam int DIV_SHIFT = TOTAL_W + $clog2(WINDOW);
	localparam int PROD_W    = TOTAL_W + DIV_SHIFT;
	localparam longint unsigned RECIP_INT =
		((64'd1 << DIV_SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
	localparam logic [DIV_SHIFT-1:0] RECIP = DIV_SHIFT'(RECIP_INT);

	logic [TOTAL_W-1:0]          tot_u;
	logic [TOTAL_W-1:0]          mag;
	logic [PROD_W-1:0]           prod_s2;
	logic                        neg_s2;
	logic [TOTAL_W-1:0]          quo;
	logic [mahs_pkg::SAMPLE_W-1:0] quo_n;

	assign tot_u = total;
	assign mag   = total[TOTAL_W-1] ? (~tot_u + TOTAL_W'(1)) : tot_u;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= PROD_W'(mag) * PROD_W'(RECIP);
			neg_s2  <= total[TOTAL_W-1];
		end
	end

	assign quo   = prod_s2[PROD_W-1:DIV_SHIFT];
	assign quo_n = quo[mahs_pkg::SAMPLE_W-1:0];
	assign avg   = neg_s2 ? (~quo_n + mahs_pkg::SAMPLE_W'(1)) : quo_n;

endmodule
